>>> rtl/keyed_reader_writer_lock_table_unit_assert.svh
// assertion macros for the lock table unit
// expects clk and rst_n in the scope of each use
`ifndef KEYED_READER_WRITER_LOCK_TABLE_UNIT_ASSERT_SVH
`define KEYED_READER_WRITER_LOCK_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define KRWLT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KRWLT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/krwlt_pkg.sv
// shared types, codes and sizing for the lock table unit
// no dependencies
package krwlt_pkg;

    localparam int SETS       = 256;
    localparam int WAYS       = 4;
    localparam int COUNT_BITS = 16;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [31:0] HASH_MUL  = 32'hF52D;
    localparam logic [31:0] HASH_XOR  = 32'h423;
    localparam int          HASH_MASK = 1023;
    localparam int          HASH_BITS = $clog2(HASH_MASK + 1);

    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SETS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [2:0]            cmd_t;
    typedef logic [2:0]            status_t;
    typedef logic [1:0]            wake_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam cmd_t CMD_RD_ACQ = 3'd0;
    localparam cmd_t CMD_RD_RTY = 3'd1;
    localparam cmd_t CMD_RD_REL = 3'd2;
    localparam cmd_t CMD_WR_ACQ = 3'd3;
    localparam cmd_t CMD_WR_RTY = 3'd4;
    localparam cmd_t CMD_WR_REL = 3'd5;

    localparam status_t ST_GRANT = 3'd0;
    localparam status_t ST_WAIT  = 3'd1;
    localparam status_t ST_REL   = 3'd2;
    localparam status_t ST_FULL  = 3'd3;
    localparam status_t ST_ERR   = 3'd4;

    localparam wake_t WAKE_NONE    = 2'd0;
    localparam wake_t WAKE_WRITER  = 2'd1;
    localparam wake_t WAKE_READERS = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] file;
        logic [31:0] chunk;
        logic        writer;
        count_t      active;
        count_t      wait_rd;
        count_t      wait_wr;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [31:0]      key_file;
        logic [31:0]      key_chunk;
        logic [SET_W-1:0] set;
    } item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

>>> rtl/krwlt_if.sv
// request and response channel interfaces
// depends on krwlt_pkg
interface krwlt_req_if;
    logic                 valid;
    logic                 ready;
    krwlt_pkg::cmd_t      command;
    logic [31:0]          key_file;
    logic [31:0]          key_chunk;

    modport source (output valid, output command, output key_file, output key_chunk,
                    input ready);
    modport sink   (input valid, input command, input key_file, input key_chunk,
                    output ready);
endinterface

interface krwlt_rsp_if;
    logic                 valid;
    logic                 ready;
    krwlt_pkg::status_t   status;
    krwlt_pkg::wake_t     wake;

    modport source (output valid, output status, output wake, input ready);
    modport sink   (input valid, input status, input wake, output ready);
endinterface

>>> rtl/krwlt_front.sv
// front end: accepts requests, hashes the key and reduces it to a set index
// depends on krwlt_pkg and krwlt_req_if
module krwlt_front
(
    input  logic                clk,
    input  logic                rst_n,
    krwlt_req_if.sink           req,
    output krwlt_pkg::item_t    push_item,
    output krwlt_pkg::hs_t      push_hs_out,
    input  logic                push_ready
);

    logic                                s1_valid_reg, s1_valid_next;
    krwlt_pkg::cmd_t                     s1_cmd_reg;
    logic [31:0]                         s1_file_reg, s1_chunk_reg;
    logic [krwlt_pkg::HASH_BITS-1:0]     s1_x_reg;

    logic                                s2_valid_reg, s2_valid_next;
    krwlt_pkg::cmd_t                     s2_cmd_reg;
    logic [31:0]                         s2_file_reg, s2_chunk_reg;
    logic [krwlt_pkg::HASH_BITS-1:0]     s2_x_reg, s2_q_reg;

    logic [2*krwlt_pkg::HASH_BITS-1:0]   hash_prod;
    logic [krwlt_pkg::HASH_BITS-1:0]     hash_low;
    logic [krwlt_pkg::HASH_BITS+krwlt_pkg::RECIP_W-1:0] q_prod;
    logic [krwlt_pkg::HASH_BITS-1:0]     rem;
    logic                                adv2, take;

    assign adv2      = !s2_valid_reg || push_ready;
    assign req.ready = !s1_valid_reg || adv2;
    assign take      = req.valid && req.ready;

    assign hash_prod = req.key_file[krwlt_pkg::HASH_BITS-1:0]
                       * krwlt_pkg::HASH_MUL[krwlt_pkg::HASH_BITS-1:0];
    assign hash_low  = hash_prod[krwlt_pkg::HASH_BITS-1:0]
                       + (req.key_chunk[krwlt_pkg::HASH_BITS-1:0]
                          ^ krwlt_pkg::HASH_XOR[krwlt_pkg::HASH_BITS-1:0]);

    // quotient by reciprocal, at most one low
    assign q_prod = s1_x_reg * krwlt_pkg::RECIP;
    assign rem    = s2_x_reg - krwlt_pkg::HASH_BITS'(s2_q_reg
                    * krwlt_pkg::HASH_BITS'(krwlt_pkg::SETS));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (adv2)
            s1_valid_next = 1'b0;
        s2_valid_next = s2_valid_reg;
        if (adv2)
            s2_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg   <= req.command;
            s1_file_reg  <= req.key_file;
            s1_chunk_reg <= req.key_chunk;
            s1_x_reg     <= hash_low;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_file_reg  <= s1_file_reg;
            s2_chunk_reg <= s1_chunk_reg;
            s2_x_reg     <= s1_x_reg;
            s2_q_reg     <= q_prod[krwlt_pkg::RECIP_SHIFT +: krwlt_pkg::HASH_BITS];
        end
    end

    always_comb
    begin
        push_item.cmd       = s2_cmd_reg;
        push_item.key_file  = s2_file_reg;
        push_item.key_chunk = s2_chunk_reg;
        if (int'(rem) >= krwlt_pkg::SETS)
            push_item.set = krwlt_pkg::SET_W'(rem - krwlt_pkg::HASH_BITS'(krwlt_pkg::SETS));
        else
            push_item.set = krwlt_pkg::SET_W'(rem);
        push_hs_out.valid = s2_valid_reg;
        push_hs_out.ready = adv2;
    end

endmodule

>>> rtl/krwlt_queue.sv
// short request queue between front and back end
// depends on krwlt_pkg
module krwlt_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  krwlt_pkg::item_t  push_item,
    input  logic              push_valid,
    output logic              push_ready,
    output krwlt_pkg::item_t  pop_item,
    output logic              pop_valid,
    input  logic              pop_ready
);

    krwlt_pkg::item_t               slot_reg [krwlt_pkg::QUEUE_DEPTH];
    logic [krwlt_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [krwlt_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [krwlt_pkg::QPTR_W:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = int'(count_reg) < krwlt_pkg::QUEUE_DEPTH;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> rtl/krwlt_back.sv
// back end: set memory, read-modify-write of one set per request, response register
// depends on krwlt_pkg and krwlt_rsp_if
module krwlt_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  krwlt_pkg::item_t  pop_item,
    input  logic              pop_valid,
    output logic              pop_ready,
    krwlt_rsp_if.source       rsp
);

    krwlt_pkg::row_t              mem [krwlt_pkg::SETS];
    krwlt_pkg::row_t              rd_data_reg;

    krwlt_pkg::back_state_t       state_reg, state_next;
    logic [krwlt_pkg::SET_W-1:0]  clr_cnt_reg, clr_cnt_next;
    krwlt_pkg::item_t             item_reg;
    logic                         out_valid_reg, out_valid_next;
    krwlt_pkg::status_t           out_status_reg;
    krwlt_pkg::wake_t             out_wake_reg;

    logic                         mem_re, mem_we, out_load, out_free;
    logic [krwlt_pkg::SET_W-1:0]  mem_waddr;
    krwlt_pkg::row_t              mem_wdata;

    krwlt_pkg::row_t              new_row;
    krwlt_pkg::status_t           ex_status;
    krwlt_pkg::wake_t             ex_wake;
    logic                         ex_write;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.wake   = out_wake_reg;

    // set lookup and update
    always_comb
    begin
        logic                        hit_found, free_found, cmd_ok, acquire;
        logic [krwlt_pkg::WAY_W-1:0] hit_way, free_way, way_sel;
        krwlt_pkg::entry_t           e;
        logic                        wblock, busy;

        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = 0; w < krwlt_pkg::WAYS; w++)
        begin
            if (rd_data_reg[w].valid)
            begin
                if (!hit_found && rd_data_reg[w].file == item_reg.key_file
                    && rd_data_reg[w].chunk == item_reg.key_chunk)
                begin
                    hit_found = 1'b1;
                    hit_way   = krwlt_pkg::WAY_W'(w);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_way   = krwlt_pkg::WAY_W'(w);
            end
        end

        cmd_ok  = item_reg.cmd inside {[krwlt_pkg::CMD_RD_ACQ:krwlt_pkg::CMD_WR_REL]};
        acquire = item_reg.cmd == krwlt_pkg::CMD_RD_ACQ || item_reg.cmd == krwlt_pkg::CMD_WR_ACQ;
        way_sel = hit_found ? hit_way : free_way;

        if (hit_found)
            e = rd_data_reg[hit_way];
        else
        begin
            e       = '0;
            e.valid = 1'b1;
            e.file  = item_reg.key_file;
            e.chunk = item_reg.key_chunk;
        end

        ex_write  = cmd_ok && (hit_found || (acquire && free_found));
        ex_wake   = krwlt_pkg::WAKE_NONE;
        if (cmd_ok && !hit_found && acquire && !free_found)
            ex_status = krwlt_pkg::ST_FULL;
        else
            ex_status = krwlt_pkg::ST_ERR;

        wblock = e.writer || e.wait_wr != '0;
        busy   = e.writer || e.active != '0;

        if (ex_write)
        begin
            case (item_reg.cmd)
                krwlt_pkg::CMD_RD_ACQ:
                begin
                    if (wblock)
                    begin
                        if (e.wait_rd != '1)
                        begin
                            e.wait_rd = e.wait_rd + 1'b1;
                            ex_status = krwlt_pkg::ST_WAIT;
                        end
                    end
                    else if (e.active != '1)
                    begin
                        e.active  = e.active + 1'b1;
                        ex_status = krwlt_pkg::ST_GRANT;
                    end
                end
                krwlt_pkg::CMD_RD_RTY:
                begin
                    if (e.wait_rd != '0)
                    begin
                        if (wblock)
                            ex_status = krwlt_pkg::ST_WAIT;
                        else if (e.active != '1)
                        begin
                            e.wait_rd = e.wait_rd - 1'b1;
                            e.active  = e.active + 1'b1;
                            ex_status = krwlt_pkg::ST_GRANT;
                        end
                    end
                end
                krwlt_pkg::CMD_RD_REL:
                begin
                    if (e.active != '0)
                    begin
                        e.active  = e.active - 1'b1;
                        ex_status = krwlt_pkg::ST_REL;
                        if (e.active == '0 && e.wait_wr != '0)
                            ex_wake = krwlt_pkg::WAKE_WRITER;
                    end
                end
                krwlt_pkg::CMD_WR_ACQ:
                begin
                    if (busy)
                    begin
                        if (e.wait_wr != '1)
                        begin
                            e.wait_wr = e.wait_wr + 1'b1;
                            ex_status = krwlt_pkg::ST_WAIT;
                        end
                    end
                    else
                    begin
                        e.writer  = 1'b1;
                        ex_status = krwlt_pkg::ST_GRANT;
                    end
                end
                krwlt_pkg::CMD_WR_RTY:
                begin
                    if (e.wait_wr != '0)
                    begin
                        if (busy)
                            ex_status = krwlt_pkg::ST_WAIT;
                        else
                        begin
                            e.wait_wr = e.wait_wr - 1'b1;
                            e.writer  = 1'b1;
                            ex_status = krwlt_pkg::ST_GRANT;
                        end
                    end
                end
                default:
                begin
                    if (e.writer)
                    begin
                        e.writer  = 1'b0;
                        ex_status = krwlt_pkg::ST_REL;
                        if (e.wait_wr != '0)
                            ex_wake = krwlt_pkg::WAKE_WRITER;
                        else if (e.wait_rd != '0)
                            ex_wake = krwlt_pkg::WAKE_READERS;
                    end
                end
            endcase
        end

        // entry frees itself once idle
        if (!e.writer && e.active == '0 && e.wait_rd == '0 && e.wait_wr == '0)
            e.valid = 1'b0;

        new_row          = rd_data_reg;
        new_row[way_sel] = e;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            krwlt_pkg::BK_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (int'(clr_cnt_reg) == krwlt_pkg::SETS - 1)
                    state_next = krwlt_pkg::BK_IDLE;
            end
            krwlt_pkg::BK_IDLE:
            begin
                if (pop_valid)
                    state_next = krwlt_pkg::BK_EXEC;
            end
            krwlt_pkg::BK_EXEC:
            begin
                if (out_free)
                    state_next = krwlt_pkg::BK_IDLE;
            end
            default:
                state_next = krwlt_pkg::BK_CLEAR;
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        mem_waddr = item_reg.set;
        mem_wdata = new_row;
        case (state_reg)
            krwlt_pkg::BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            krwlt_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                mem_re    = pop_valid;
            end
            krwlt_pkg::BK_EXEC:
            begin
                out_load = out_free;
                mem_we   = out_free && ex_write;
            end
            default:
                pop_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= krwlt_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            item_reg <= pop_item;
        if (out_load)
        begin
            out_status_reg <= ex_status;
            out_wake_reg   <= ex_wake;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[pop_item.set];
    end

endmodule

>>> rtl/keyed_reader_writer_lock_table_unit.sv
// keyed reader/writer lock table: top level joining front end, queue and back end
// a request passes the second hash stage, the queue slot, the set read register and the
// response register in turn; the last loads when the response register is free
// the back end starts a new request only once the read-modify-write of the previous one is done
// after reset the back end clears the set memory, one set per cycle,
// and takes no request from the queue until that sweep ends
module keyed_reader_writer_lock_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    krwlt_req_if.sink   req,
    krwlt_rsp_if.source rsp
);

    krwlt_pkg::item_t  push_item, pop_item;
    krwlt_pkg::hs_t    push_hs;
    logic              push_ready, pop_valid, pop_ready;

    krwlt_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .push_item   (push_item),
        .push_hs_out (push_hs),
        .push_ready  (push_ready)
    );

    krwlt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_hs.valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    krwlt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );

endmodule

>>> rtl/krwlt_checker.sv
// port-level checks for the lock table unit, bound to the top level
// depends on krwlt_pkg and the assertion macro header
`include "keyed_reader_writer_lock_table_unit_assert.svh"

module krwlt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input krwlt_pkg::status_t rsp_status,
    input krwlt_pkg::wake_t   rsp_wake
);

    `KRWLT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_wake), "stalled response changed")
    `KRWLT_ASSERT_IMP(a_wake_rel, rsp_valid && rsp_wake != krwlt_pkg::WAKE_NONE, rsp_status == krwlt_pkg::ST_REL, "wake without release")
    `KRWLT_ASSERT_IMP(a_codes, rsp_valid, rsp_status <= krwlt_pkg::ST_ERR && rsp_wake <= krwlt_pkg::WAKE_READERS, "bad response code")

endmodule

bind keyed_reader_writer_lock_table_unit krwlt_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_wake   (rsp.wake)
);

>>> bench/keyed_reader_writer_lock_table_unit_tb.sv
// testbench for the keyed reader/writer lock table unit
// drives lock requests, predicts status and wake from its own table model
// depends on krwlt_pkg, krwlt_if and the unit's rtl
`timescale 1ns / 1ps

module keyed_reader_writer_lock_table_unit_tb;

    localparam int N_ENT = krwlt_pkg::SETS * krwlt_pkg::WAYS;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << krwlt_pkg::COUNT_BITS) - 1);
    localparam int WATCH_LIMIT = 4 * krwlt_pkg::SETS + 2000;

    typedef struct packed {
        krwlt_pkg::cmd_t cmd;
        logic [31:0]     kf;
        logic [31:0]     kc;
    } lock_req_t;

    typedef struct packed {
        krwlt_pkg::status_t st;
        krwlt_pkg::wake_t   wk;
    } lock_rsp_t;

    logic clk;
    logic rst_n;

    krwlt_req_if req ();
    krwlt_rsp_if rsp ();

    keyed_reader_writer_lock_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // model table
    logic        t_valid  [N_ENT];
    logic [31:0] t_file   [N_ENT];
    logic [31:0] t_chunk  [N_ENT];
    logic        t_writer [N_ENT];
    logic [31:0] t_active [N_ENT];
    logic [31:0] t_wrd    [N_ENT];
    logic [31:0] t_wwr    [N_ENT];

    lock_req_t pending_reqs [$];
    lock_rsp_t expected_rsps [$];
    int        errors = 0;
    int        src_idle_pct = 34;
    int        snk_idle_pct = 60;
    bit        hold_src = 0;
    bit        stim_done = 0;
    bit        in_fire = 0;
    int        quiet_cycles = 0;

    // small key pool so locks collide, plus one crowded set
    logic [31:0] pool_f [16];
    logic [31:0] pool_c [16];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int set_index(logic [31:0] f, logic [31:0] c);
        logic [31:0] h;
        h = f * krwlt_pkg::HASH_MUL + (c ^ krwlt_pkg::HASH_XOR);
        return int'(h & 32'(krwlt_pkg::HASH_MASK)) % krwlt_pkg::SETS;
    endfunction

    function automatic lock_rsp_t lock_outcome(lock_req_t r);
        lock_rsp_t o;
        int base;
        int hit;
        int fw;
        int e;
        bit wblock;
        bit busy;
        base = set_index(r.kf, r.kc) * krwlt_pkg::WAYS;
        hit = -1;
        fw = -1;
        o.st = krwlt_pkg::ST_ERR;
        o.wk = krwlt_pkg::WAKE_NONE;
        for (int w = 0; w < krwlt_pkg::WAYS; w++)
        begin
            e = base + w;
            if (t_valid[e])
            begin
                if (hit < 0 && t_file[e] == r.kf && t_chunk[e] == r.kc)
                    hit = e;
            end
            else if (fw < 0)
                fw = e;
        end
        if (r.cmd > krwlt_pkg::CMD_WR_REL)
            o.st = krwlt_pkg::ST_ERR;
        else if (hit < 0 && (r.cmd == krwlt_pkg::CMD_RD_ACQ || r.cmd == krwlt_pkg::CMD_WR_ACQ))
        begin
            if (fw < 0)
                o.st = krwlt_pkg::ST_FULL;
            else
            begin
                t_valid[fw] = 1'b1;
                t_file[fw] = r.kf;
                t_chunk[fw] = r.kc;
                t_writer[fw] = 1'b0;
                t_active[fw] = 0;
                t_wrd[fw] = 0;
                t_wwr[fw] = 0;
                hit = fw;
            end
        end
        if (hit >= 0 && r.cmd <= krwlt_pkg::CMD_WR_REL)
        begin
            e = hit;
            wblock = t_writer[e] || t_wwr[e] != 0;
            busy = t_writer[e] || t_active[e] != 0;
            o.st = krwlt_pkg::ST_ERR;
            case (r.cmd)
                krwlt_pkg::CMD_RD_ACQ:
                    if (wblock)
                    begin
                        if (t_wrd[e] < CNT_MAX)
                        begin
                            t_wrd[e]++;
                            o.st = krwlt_pkg::ST_WAIT;
                        end
                    end
                    else if (t_active[e] < CNT_MAX)
                    begin
                        t_active[e]++;
                        o.st = krwlt_pkg::ST_GRANT;
                    end
                krwlt_pkg::CMD_RD_RTY:
                    if (t_wrd[e] != 0)
                    begin
                        if (wblock)
                            o.st = krwlt_pkg::ST_WAIT;
                        else if (t_active[e] < CNT_MAX)
                        begin
                            t_wrd[e]--;
                            t_active[e]++;
                            o.st = krwlt_pkg::ST_GRANT;
                        end
                    end
                krwlt_pkg::CMD_RD_REL:
                    if (t_active[e] != 0)
                    begin
                        t_active[e]--;
                        o.st = krwlt_pkg::ST_REL;
                        if (t_active[e] == 0 && t_wwr[e] != 0)
                            o.wk = krwlt_pkg::WAKE_WRITER;
                    end
                krwlt_pkg::CMD_WR_ACQ:
                    if (busy)
                    begin
                        if (t_wwr[e] < CNT_MAX)
                        begin
                            t_wwr[e]++;
                            o.st = krwlt_pkg::ST_WAIT;
                        end
                    end
                    else
                    begin
                        t_writer[e] = 1'b1;
                        o.st = krwlt_pkg::ST_GRANT;
                    end
                krwlt_pkg::CMD_WR_RTY:
                    if (t_wwr[e] != 0)
                    begin
                        if (busy)
                            o.st = krwlt_pkg::ST_WAIT;
                        else
                        begin
                            t_wwr[e]--;
                            t_writer[e] = 1'b1;
                            o.st = krwlt_pkg::ST_GRANT;
                        end
                    end
                default:
                    if (t_writer[e])
                    begin
                        t_writer[e] = 1'b0;
                        o.st = krwlt_pkg::ST_REL;
                        if (t_wwr[e] != 0)
                            o.wk = krwlt_pkg::WAKE_WRITER;
                        else if (t_wrd[e] != 0)
                            o.wk = krwlt_pkg::WAKE_READERS;
                    end
            endcase
            if (!t_writer[e] && t_active[e] == 0 && t_wrd[e] == 0 && t_wwr[e] == 0)
                t_valid[e] = 1'b0;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void push_lock(krwlt_pkg::cmd_t c, logic [31:0] f, logic [31:0] k);
        lock_req_t r;
        r.cmd = c;
        r.kf = f;
        r.kc = k;
        pending_reqs.push_back(r);
    endfunction

    // chunk that lands key file f in set s
    function automatic logic [31:0] chunk_for_set(logic [31:0] f, int s, logic [31:0] hi);
        logic [31:0] t;
        t = (32'(s) - f * krwlt_pkg::HASH_MUL) & 32'h3FF;
        return (t | (hi << 10)) ^ krwlt_pkg::HASH_XOR;
    endfunction

    // request taken at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= req.valid && req.ready;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.command <= '0;
            req.key_file <= '0;
            req.key_chunk <= '0;
        end
        else if (!req.valid || in_fire)
        begin
            if (pending_reqs.size() > 0 && !hold_src &&
                $urandom_range(99) >= src_idle_pct)
            begin
                lock_req_t r;
                r = pending_reqs.pop_front();
                req.valid <= 1'b1;
                req.command <= r.cmd;
                req.key_file <= r.kf;
                req.key_chunk <= r.kc;
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // monitor: predict on request, check on response
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            lock_req_t r;
            lock_rsp_t want;
            if (req.valid && req.ready)
            begin
                r.cmd = req.command;
                r.kf = req.key_file;
                r.kc = req.key_chunk;
                expected_rsps.push_back(lock_outcome(r));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response status", rsp.status, -1);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.st)
                        report_mismatch("status", rsp.status, want.st);
                    if (rsp.wake !== want.wk)
                        report_mismatch("wake", rsp.wake, want.wk);
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCH_LIMIT && !stim_done)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void add_random(int n);
        krwlt_pkg::cmd_t c;
        int k;
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            k = $urandom_range(15);
            c = krwlt_pkg::cmd_t'($urandom_range(5));
            if (roll < 3)
                push_lock(krwlt_pkg::cmd_t'($urandom_range(7)), $urandom, $urandom);
            else if (roll < 6)
                push_lock(krwlt_pkg::cmd_t'($urandom_range(6, 7)), pool_f[k], pool_c[k]);
            else
                push_lock(c, pool_f[k], pool_c[k]);
        end
    endfunction

    initial
    begin
        int s;
        for (int e = 0; e < N_ENT; e++)
        begin
            t_valid[e] = 1'b0;
            t_file[e] = '0;
            t_chunk[e] = '0;
            t_writer[e] = 1'b0;
            t_active[e] = 0;
            t_wrd[e] = 0;
            t_wwr[e] = 0;
        end
        req.valid = 1'b0;
        req.command = '0;
        req.key_file = '0;
        req.key_chunk = '0;
        rsp.ready = 1'b0;
        rst_n = 1'b0;
        s = $urandom_range(krwlt_pkg::SETS - 1);
        for (int i = 0; i < 16; i++)
        begin
            pool_f[i] = $urandom;
            // first six keys share one set to exercise the full case
            pool_c[i] = (i < 6) ? chunk_for_set(pool_f[i], s, $urandom) : $urandom;
        end
        pool_f[6] = '0;
        pool_c[6] = '0;
        pool_f[7] = '1;
        pool_c[7] = '1;

        // directed
        push_lock(krwlt_pkg::CMD_RD_RTY, pool_f[7], pool_c[7]);
        push_lock(krwlt_pkg::CMD_RD_REL, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_WR_REL, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_WR_RTY, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::cmd_t'(6), pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::cmd_t'(7), pool_f[7], pool_c[7]);
        push_lock(krwlt_pkg::CMD_RD_ACQ, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_WR_ACQ, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_RD_ACQ, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_RD_REL, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_WR_RTY, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_WR_REL, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_RD_RTY, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_RD_REL, pool_f[6], pool_c[6]);
        push_lock(krwlt_pkg::CMD_WR_ACQ, pool_f[7], pool_c[7]);
        for (int i = 0; i < 5; i++)
            push_lock(krwlt_pkg::CMD_WR_ACQ, pool_f[i], pool_c[i]);
        push_lock(krwlt_pkg::CMD_WR_REL, pool_f[0], pool_c[0]);
        push_lock(krwlt_pkg::CMD_RD_ACQ, pool_f[4], pool_c[4]);
        push_lock(krwlt_pkg::CMD_WR_REL, pool_f[7], pool_c[7]);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_random(580);
        wait (pending_reqs.size() == 0);
        src_idle_pct = 60;
        snk_idle_pct = 34;
        hold_src = 1'b1;
        wait (expected_rsps.size() == 0);
        hold_src = 1'b0;
        add_random(580);
        wait (pending_reqs.size() == 0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        add_random(580);
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        while (req.valid)
            @(posedge clk);
        fork
            wait (expected_rsps.size() == 0);
            repeat (20 * WATCH_LIMIT) @(posedge clk);
        join_any
        disable fork;
        stim_done = 1'b1;
        repeat (20) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            $display("missing %0d responses", expected_rsps.size());
            errors++;
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
